// ===== rtl/sdw_pkg.sv =====
// Shared types and constants for the sequence dedup window block.
// Item and result transaction structs, status and register codes, controller states.
// No dependencies.
package sdw_pkg;

  localparam int SEQ_W     = 64;
  localparam int DIGEST_W  = 64;
  localparam int WINDOW_W  = 7;
  localparam int LIMIT_W   = 11;
  localparam int STREAM_W  = 4;
  localparam logic [1:0] MOD_LAST = 2'd3;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 7'd64;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 11'd256;

  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_MISMATCH  = 2'd2,
    ST_FENCED    = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_WINDOW_SIZE   = 1'b0,
    CFG_HISTORY_LIMIT = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_LOOK,
    S_SWEEP
  } state_t;

  typedef struct packed {
    logic [STREAM_W-1:0] stream;
    logic [SEQ_W-1:0]    sequence_req;
    logic [DIGEST_W-1:0] digest;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic               reordered;
    logic               evicted;
    logic [LIMIT_W-1:0] retained;
  } result_t;

endpackage

// ===== rtl/sequence_dedup_window.sv =====
// Top level of the sequence dedup window: per-stream anti-replay check with digest compare.
// Slot and stream state live in two memories with registered reads inside this module.
// Depends on sdw_pkg.
//
// Usage: an item is taken when start is high and busy is low; its result shows on result
// for exactly one cycle with done high, once the decision state has been passed, and
// cannot be held off. A rejected item (duplicate, mismatch, fenced, stream out of range)
// occupies the block through a slot pick in registered steps (sequence modulo WINDOW_SLOTS:
// 16-bit chunks folded against their constant residues, a reciprocal-multiply quotient
// estimate, a subtract, one correction), one memory read and one decision step, then the
// idle state in which the next item is taken; an accepted item first sweeps its stream's
// slot row through the single read port, one slot a cycle, to retire aged entries and to
// store its own.
// After reset the block clears all NUM_STREAMS * 2**ceil(log2(WINDOW_SLOTS)) slot entries
// and all stream entries with busy high. Configuration writes are taken in every cycle
// (cfg_ready is tied high) and must only be issued while no transaction is in flight.
module sequence_dedup_window #(
  parameter int NUM_STREAMS  = 16,
  parameter int WINDOW_SLOTS = 64,
  parameter int HISTORY_MAX  = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  sdw_pkg::item_t         item,
  output logic                   done,
  output sdw_pkg::result_t       result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  sdw_pkg::cfg_index_t    cfg_index,
  input  logic [sdw_pkg::LIMIT_W-1:0] cfg_data
);

  localparam int SW         = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int SLW        = $clog2(WINDOW_SLOTS);
  localparam int SAW        = SW + SLW;
  localparam int SLOT_DEPTH = NUM_STREAMS << SLW;
  localparam int CW         = SLW + 1;
  localparam int RW         = SLW + 1;
  localparam int FW         = 28;
  localparam int PW         = 2 * FW;
  localparam longint RES1   = 65536 % WINDOW_SLOTS;
  localparam longint RES2   = (RES1 * 65536) % WINDOW_SLOTS;
  localparam longint RES3   = (RES2 * 65536) % WINDOW_SLOTS;
  localparam longint RECIP  = (longint'(1) << FW) / WINDOW_SLOTS;

  typedef struct packed {
    logic                         valid;
    logic [sdw_pkg::SEQ_W-1:0]    tag;
    logic [sdw_pkg::DIGEST_W-1:0] dig;
  } slot_t;

  typedef struct packed {
    logic                        has_mark;
    logic [sdw_pkg::SEQ_W-1:0]   wm;
    logic [sdw_pkg::LIMIT_W-1:0] depth;
  } strm_t;

  sdw_pkg::state_t state, state_next;

  logic [sdw_pkg::WINDOW_W-1:0] win_cfg;
  logic [sdw_pkg::LIMIT_W-1:0]  lim_cfg;
  logic [sdw_pkg::WINDOW_W-1:0] w_eff;
  logic [sdw_pkg::LIMIT_W-1:0]  lim_eff;

  logic [SAW-1:0]                clr;
  logic [SW-1:0]                 sidx;
  logic                          in_range;
  logic [sdw_pkg::SEQ_W-1:0]     seq;
  logic [sdw_pkg::DIGEST_W-1:0]  dig;
  logic [1:0]                    ncnt;
  logic [SLW-1:0]                rem;
  logic [FW-1:0]                 fold, fold_calc;
  logic [PW-1:0]                 prod;
  logic [FW-1:0]                 quo, quo_calc;
  logic [RW-1:0]                 rest, rest_calc;
  logic [SLW-1:0]                rem_calc;
  logic [sdw_pkg::SEQ_W-1:0]     wm_new;
  logic                          store_new;
  logic [CW-1:0]                 cnt;
  logic [CW-1:0]                 k_prev;

  slot_t          slot_mem [SLOT_DEPTH];
  slot_t          slot_rd, slot_wd;
  logic           slot_we;
  logic [SAW-1:0] slot_wa, slot_ra;

  strm_t          strm_mem [NUM_STREAMS];
  strm_t          strm_rd, strm_wd;
  logic           strm_we;
  logic [SW-1:0]  strm_wa, strm_ra;

  logic                          hit, below, fenced, accept, keep_new, evict, drop;
  logic [sdw_pkg::SEQ_W-1:0]     wm_calc;
  logic [sdw_pkg::LIMIT_W:0]     dep_inc;
  logic [sdw_pkg::LIMIT_W-1:0]   dep_new;
  sdw_pkg::result_t              look_result;

  assign cfg_ready = 1'b1;

  assign w_eff   = (32'(win_cfg) > WINDOW_SLOTS) ? sdw_pkg::WINDOW_W'(WINDOW_SLOTS) : win_cfg;
  assign lim_eff = (32'(lim_cfg) > HISTORY_MAX) ? sdw_pkg::LIMIT_W'(HISTORY_MAX) : lim_cfg;

  // slot pick: fold, reciprocal quotient (low by at most one), subtract, correct
  assign fold_calc = FW'(seq[15:0]) + FW'(seq[31:16]) * FW'(RES1) +
                     FW'(seq[47:32]) * FW'(RES2) + FW'(seq[63:48]) * FW'(RES3);
  assign prod      = PW'(fold) * PW'(RECIP);
  assign quo_calc  = prod[PW-1:FW];
  assign rest_calc = fold[RW-1:0] - quo[RW-1:0] * RW'(WINDOW_SLOTS);
  assign rem_calc  = (rest >= RW'(WINDOW_SLOTS)) ? SLW'(rest - RW'(WINDOW_SLOTS))
                                                 : rest[SLW-1:0];

  // lookup decision
  always_comb begin
    hit      = strm_rd.has_mark && slot_rd.valid && (slot_rd.tag == seq);
    below    = strm_rd.has_mark && (seq < strm_rd.wm);
    fenced   = below && ((strm_rd.wm - seq) > 64'(w_eff));
    accept   = in_range && !hit && !fenced;
    wm_calc  = (!strm_rd.has_mark || (seq > strm_rd.wm)) ? seq : strm_rd.wm;
    keep_new = (wm_calc - seq) < 64'(w_eff);
    dep_inc  = {1'b0, strm_rd.depth} + 1'b1;
    evict    = dep_inc > {1'b0, lim_eff};
    dep_new  = evict ? lim_eff : dep_inc[sdw_pkg::LIMIT_W-1:0];

    look_result.status    = sdw_pkg::ST_ACCEPTED;
    look_result.reordered = 1'b0;
    look_result.evicted   = 1'b0;
    look_result.retained  = strm_rd.depth;
    if (!in_range) begin
      look_result.status   = sdw_pkg::ST_FENCED;
      look_result.retained = '0;
    end else if (hit) begin
      look_result.status = (slot_rd.dig == dig) ? sdw_pkg::ST_DUPLICATE : sdw_pkg::ST_MISMATCH;
    end else if (fenced) begin
      look_result.status = sdw_pkg::ST_FENCED;
    end else begin
      look_result.reordered = below;
      look_result.evicted   = evict;
      look_result.retained  = dep_new;
    end
  end

  assign k_prev = cnt - 1'b1;
  assign drop   = slot_rd.valid &&
                  ((slot_rd.tag > wm_new) || ((wm_new - slot_rd.tag) >= 64'(w_eff)));

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    slot_we    = 1'b0;
    slot_wa    = {sidx, k_prev[SLW-1:0]};
    slot_wd    = slot_rd;
    slot_ra    = {sidx, rem};
    strm_we    = 1'b0;
    strm_wa    = sidx;
    strm_wd    = '0;
    strm_ra    = sidx;
    case (state)
      sdw_pkg::S_CLEAR: begin
        slot_we = 1'b1;
        slot_wa = clr;
        slot_wd = '0;
        strm_we = 32'(clr) < NUM_STREAMS;
        strm_wa = clr[SW-1:0];
        if (clr == SAW'(SLOT_DEPTH - 1)) begin
          state_next = sdw_pkg::S_IDLE;
        end
      end
      sdw_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = sdw_pkg::S_MOD;
        end
      end
      sdw_pkg::S_MOD: begin
        if (ncnt == sdw_pkg::MOD_LAST) begin
          state_next = sdw_pkg::S_READ;
        end
      end
      sdw_pkg::S_READ: begin
        state_next = sdw_pkg::S_LOOK;
      end
      sdw_pkg::S_LOOK: begin
        if (accept) begin
          strm_we    = 1'b1;
          strm_wd    = '{has_mark: 1'b1, wm: wm_calc, depth: dep_new};
          state_next = sdw_pkg::S_SWEEP;
        end else begin
          state_next = sdw_pkg::S_IDLE;
        end
      end
      sdw_pkg::S_SWEEP: begin
        slot_ra = {sidx, cnt[SLW-1:0]};
        if (cnt != '0) begin
          if (store_new && (k_prev[SLW-1:0] == rem)) begin
            slot_we = 1'b1;
            slot_wd = '{valid: 1'b1, tag: seq, dig: dig};
          end else if (drop) begin
            slot_we       = 1'b1;
            slot_wd.valid = 1'b0;
          end
        end
        if (32'(cnt) == WINDOW_SLOTS) begin
          state_next = sdw_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sdw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sdw_pkg::S_CLEAR;
      clr     <= '0;
      done    <= 1'b0;
      win_cfg <= sdw_pkg::WINDOW_RESET;
      lim_cfg <= sdw_pkg::LIMIT_RESET;
    end else begin
      state <= state_next;
      done  <= (state == sdw_pkg::S_LOOK);
      if (state == sdw_pkg::S_CLEAR) begin
        clr <= clr + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sdw_pkg::CFG_WINDOW_SIZE:   win_cfg <= cfg_data[sdw_pkg::WINDOW_W-1:0];
          sdw_pkg::CFG_HISTORY_LIMIT: lim_cfg <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == sdw_pkg::S_IDLE) && start) begin
      sidx     <= SW'(item.stream);
      in_range <= 32'(item.stream) < NUM_STREAMS;
      seq      <= item.sequence_req;
      dig      <= item.digest;
      ncnt     <= '0;
    end
    // stages settle one per cycle while seq holds still
    if (state == sdw_pkg::S_MOD) begin
      fold <= fold_calc;
      quo  <= quo_calc;
      rest <= rest_calc;
      rem  <= rem_calc;
      ncnt <= ncnt + 1'b1;
    end
    if (state == sdw_pkg::S_LOOK) begin
      result    <= look_result;
      wm_new    <= wm_calc;
      store_new <= keep_new;
      cnt       <= '0;
    end
    if (state == sdw_pkg::S_SWEEP) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (strm_we) begin
      strm_mem[strm_wa] <= strm_wd;
    end
    strm_rd <= strm_mem[strm_ra];
  end

endmodule

// ===== rtl/sdw_checker.sv =====
// Port-level checks for sequence_dedup_window, attached by the bind at the end.
// Depends on sdw_pkg and the top level's port list.
module sdw_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input sdw_pkg::result_t result
);

  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("transaction accepted without going busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_reject_flags: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != sdw_pkg::ST_ACCEPTED)) |-> (!result.reordered && !result.evicted))
    else $error("flags set on a rejected transaction");

endmodule

bind sequence_dedup_window sdw_checker u_sdw_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
